// ===== hw/rtl/ppmsp_pkg.sv =====
// shared types and constants of the ppm stream parser
`timescale 1ns / 1ps
package ppmsp_pkg;

  localparam int MAX_TOKEN_CHARS = 16;
  localparam int DIM_BITS        = 14;
  localparam int SAMPLE_BITS     = 8;
  localparam int TLEN_BITS       = $clog2(MAX_TOKEN_CHARS + 2);
  localparam int PIX_BITS        = 2 * DIM_BITS;
  localparam int RAW_BITS        = PIX_BITS + 2;
  localparam int ACC_WIDE_BITS   = DIM_BITS + 4;
  localparam int CFG_INDEX_BITS  = 2;

  localparam int BYTE_FIFO_DEPTH = 4;
  localparam int BYTE_PTR_BITS   = $clog2(BYTE_FIFO_DEPTH);
  localparam int BYTE_CNT_BITS   = $clog2(BYTE_FIFO_DEPTH + 1);
  localparam int OUT_DEPTH       = 2;
  localparam int OUT_PTR_BITS    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS    = $clog2(OUT_DEPTH + 1);

  localparam logic [DIM_BITS-1:0]    DIM_LIMIT        = '1;
  localparam logic [DIM_BITS-1:0]    MAX_DIM_RESET    = DIM_BITS'(8224);
  localparam logic [DIM_BITS-1:0]    MAX_MAXVAL_RESET = DIM_BITS'(256);
  localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE_RESET = SAMPLE_BITS'(255);
  localparam logic [DIM_BITS-1:0]    MAGIC_LIMIT      = DIM_BITS'(7);
  localparam logic [DIM_BITS-1:0]    MAGIC_P3         = DIM_BITS'(3);
  localparam logic [DIM_BITS-1:0]    MAGIC_P6         = DIM_BITS'(6);

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MAX_DIMENSION = 2'd0,
    CFG_MAX_MAXVAL    = 2'd1,
    CFG_MAX_SAMPLE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_MAGIC  = 3'd0,
    KIND_WIDTH  = 3'd1,
    KIND_HEIGHT = 3'd2,
    KIND_MAXVAL = 3'd3,
    KIND_SAMPLE = 3'd4,
    KIND_ERROR  = 3'd5,
    KIND_END    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_P     = 3'd1,
    ERR_MAGIC    = 3'd2,
    ERR_TOO_LONG = 3'd3,
    ERR_RANGE    = 3'd4
  } err_code_t;

  typedef enum logic [3:0] {
    PH_EXPECT_P = 4'd0,
    PH_MAGIC    = 4'd1,
    PH_SKIP_W   = 4'd2,
    PH_TOK_W    = 4'd3,
    PH_SKIP_H   = 4'd4,
    PH_TOK_H    = 4'd5,
    PH_SKIP_M   = 4'd6,
    PH_TOK_M    = 4'd7,
    PH_RAW      = 4'd8,
    PH_SKIP_S   = 4'd9,
    PH_TOK_S    = 4'd10,
    PH_DONE     = 4'd11
  } phase_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       is_ws;
    logic       is_lf;
    logic       is_hash;
    logic       is_p;
    logic       is_digit;
    logic [3:0] digit;
  } cls_t;

  // one result transaction
  typedef struct packed {
    kind_t               kind;
    logic [DIM_BITS-1:0] value;
    err_code_t           code;
    logic                last;
  } res_t;

endpackage

// ===== hw/rtl/ppm_stream_parser.sv =====
// ppm stream parser: byte-serial p3/p6 header and sample parser
// usage:
//   input side is a queue: drive data_byte and end_of_file with push; a byte
//   transaction completes when push is high and full is low. end_of_file marks
//   the final byte of a file and returns the parser to its start state.
//   result side is a queue: while empty is low the oldest result sits on
//   kind, value, error_code and last; pop takes it.
//   config writes (cfg_write, cfg_index, cfg_data) set max_dimension,
//   max_maxval and max_sample; write them only while the parser is idle.
// timing:
//   one byte per cycle sustained while the result queue has room; each byte
//   updates the parser state when it is taken. a result passes through the
//   byte queue, then the parser into the two-entry result queue.
//   the pixel count register feeding the p6 raw counter is registered from
//   width and height.
// reset (rst, synchronous): empties both queues, sets the parser to expect
//   the leading P and loads the register defaults.
// stall: while pop is low the result queue fills, the parser halts and the
//   four-entry byte queue absorbs input until full rises.
`timescale 1ns / 1ps
module ppm_stream_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [7:0]                           data_byte,
  input  logic                                 end_of_file,
  input  logic                                 push,
  output logic                                 full,
  output logic [2:0]                           kind,
  output logic [ppmsp_pkg::DIM_BITS-1:0]       value,
  output logic [2:0]                           error_code,
  output logic                                 last,
  output logic                                 empty,
  input  logic                                 pop,
  input  logic                                 cfg_write,
  input  logic [ppmsp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ppmsp_pkg::DIM_BITS-1:0]       cfg_data
);
  import ppmsp_pkg::*;

  cls_t cls_in;
  cls_t cls_head;
  logic q_empty;
  logic q_take;
  res_t out_item;

  ppmsp_front u_front (
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .cls         (cls_in)
  );

  ppmsp_byte_fifo u_byte_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (cls_in),
    .full    (full),
    .empty   (q_empty),
    .rd_en   (q_take),
    .rd_item (cls_head)
  );

  ppmsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_item   (cls_head),
    .in_take   (q_take),
    .out_empty (empty),
    .out_item  (out_item),
    .pop       (pop),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  assign kind       = out_item.kind;
  assign value      = out_item.value;
  assign error_code = out_item.code;
  assign last       = out_item.last;

endmodule

// ===== hw/rtl/ppmsp_front.sv =====
// front end: classifies each incoming byte for the parser
`timescale 1ns / 1ps
module ppmsp_front (
  input  logic [7:0]      data_byte,
  input  logic            end_of_file,
  output ppmsp_pkg::cls_t cls
);
  import ppmsp_pkg::*;

  logic [7:0] digit_off;

  assign digit_off = data_byte - CHAR_ZERO;

  always_comb begin
    cls.data     = data_byte;
    cls.eof      = end_of_file;
    cls.is_lf    = (data_byte == CHAR_LF);
    cls.is_ws    = (data_byte == CHAR_LF) || (data_byte == CHAR_SPACE);
    cls.is_hash  = (data_byte == CHAR_HASH);
    cls.is_p     = (data_byte == CHAR_P);
    cls.is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    cls.digit    = digit_off[3:0];
  end

endmodule

// ===== hw/rtl/ppmsp_byte_fifo.sv =====
// short queue of classified bytes between front end and parser
`timescale 1ns / 1ps
module ppmsp_byte_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ppmsp_pkg::cls_t wr_item,
  output logic            full,
  output logic            empty,
  input  logic            rd_en,
  output ppmsp_pkg::cls_t rd_item
);
  import ppmsp_pkg::*;

  cls_t                   slots [BYTE_FIFO_DEPTH];
  logic [BYTE_PTR_BITS-1:0] wr_ptr;
  logic [BYTE_PTR_BITS-1:0] rd_ptr;
  logic [BYTE_CNT_BITS-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign full    = (count == BYTE_CNT_BITS'(BYTE_FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ppmsp_back.sv =====
// back end: parse state machine, range checks and result queue
`timescale 1ns / 1ps
module ppmsp_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  ppmsp_pkg::cls_t                      in_item,
  output logic                                 in_take,
  output logic                                 out_empty,
  output ppmsp_pkg::res_t                      out_item,
  input  logic                                 pop,
  input  logic                                 cfg_write,
  input  logic [ppmsp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ppmsp_pkg::DIM_BITS-1:0]       cfg_data
);
  import ppmsp_pkg::*;

  typedef struct packed {
    phase_t              phase;
    logic                fail;
    kind_t               kind;
    logic [DIM_BITS-1:0] value;
    err_code_t           code;
    logic                set_magic;
    logic                set_width;
    logic                set_height;
    logic                load_raw;
  } fin_t;

  // config registers
  logic [DIM_BITS-1:0]    max_dimension;
  logic [DIM_BITS-1:0]    max_maxval;
  logic [SAMPLE_BITS-1:0] max_sample;

  // parse state
  phase_t                 phase, phase_next;
  logic [DIM_BITS-1:0]    acc, acc_next;
  logic [TLEN_BITS-1:0]   tlen, tlen_next;
  logic                   line_start, line_start_next;
  logic                   in_comment, in_comment_next;
  logic                   digits_stopped, digits_stopped_next;
  logic                   token_overflow, token_overflow_next;
  logic                   error_latched, error_latched_next;
  logic                   magic_p6, magic_p6_next;
  logic [DIM_BITS-1:0]    frame_width, frame_width_next;
  logic [DIM_BITS-1:0]    frame_height, frame_height_next;
  logic [RAW_BITS-1:0]    raw_remaining, raw_remaining_next;
  logic [PIX_BITS-1:0]    pixels;
  logic [RAW_BITS-1:0]    raw_total;

  // step results
  logic                   feed;
  logic                   fin_req;
  logic                   do_fin;
  logic                   fin_lf;
  logic [ACC_WIDE_BITS-1:0] acc_wide;
  fin_t                   fin;
  logic                   res_valid;
  res_t                   res;

  // result queue
  res_t                   oq [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] oq_wr;
  logic [OUT_PTR_BITS-1:0] oq_rd;
  logic [OUT_CNT_BITS-1:0] oq_cnt;
  logic                   out_room;
  logic                   res_push;
  logic                   res_pop;

  function automatic logic is_token_phase(input phase_t ph);
    return (ph == PH_MAGIC) || (ph == PH_TOK_W) || (ph == PH_TOK_H) ||
           (ph == PH_TOK_M) || (ph == PH_TOK_S);
  endfunction

  // ends the open token and checks it against its limit
  function automatic fin_t finish_token(
    input phase_t                 ph,
    input logic [DIM_BITS-1:0]    v,
    input logic                   bad,
    input logic                   is_p6,
    input logic                   pix_nz,
    input logic [DIM_BITS-1:0]    lim_dim,
    input logic [DIM_BITS-1:0]    lim_maxval,
    input logic [SAMPLE_BITS-1:0] lim_sample
  );
    fin_t f;
    f            = '0;
    f.phase      = ph;
    f.kind       = KIND_ERROR;
    f.value      = '0;
    f.code       = ERR_NONE;
    unique case (ph)
      PH_MAGIC: begin
        if (bad || v > MAGIC_LIMIT) begin
          f.fail = 1'b1;
          f.code = ERR_RANGE;
        end else if (v != MAGIC_P3 && v != MAGIC_P6) begin
          f.fail = 1'b1;
          f.code = ERR_MAGIC;
        end else begin
          f.set_magic = 1'b1;
          f.kind      = KIND_MAGIC;
          f.value     = v;
          f.phase     = PH_SKIP_W;
        end
      end
      PH_TOK_W: begin
        if (bad || v > lim_dim) begin
          f.fail = 1'b1;
          f.code = ERR_RANGE;
        end else begin
          f.set_width = 1'b1;
          f.kind      = KIND_WIDTH;
          f.value     = v;
          f.phase     = PH_SKIP_H;
        end
      end
      PH_TOK_H: begin
        if (bad || v > lim_dim) begin
          f.fail = 1'b1;
          f.code = ERR_RANGE;
        end else begin
          f.set_height = 1'b1;
          f.kind       = KIND_HEIGHT;
          f.value      = v;
          f.phase      = PH_SKIP_M;
        end
      end
      PH_TOK_M: begin
        if (bad || v > lim_maxval) begin
          f.fail = 1'b1;
          f.code = ERR_RANGE;
        end else begin
          f.kind  = KIND_MAXVAL;
          f.value = v;
          if (is_p6) begin
            f.load_raw = 1'b1;
            f.phase    = pix_nz ? PH_RAW : PH_DONE;
          end else begin
            f.phase = PH_SKIP_S;
          end
        end
      end
      PH_TOK_S: begin
        if (bad || v > DIM_BITS'(lim_sample)) begin
          f.fail = 1'b1;
          f.code = ERR_RANGE;
        end else begin
          f.kind  = KIND_SAMPLE;
          f.value = v;
          f.phase = PH_SKIP_S;
        end
      end
      default: begin
      end
    endcase
    return f;
  endfunction

  assign out_room  = (oq_cnt != OUT_CNT_BITS'(OUT_DEPTH));
  assign in_take   = in_valid && out_room;
  assign res_push  = in_take && res_valid;
  assign out_empty = (oq_cnt == '0);
  assign res_pop   = pop && !out_empty;
  assign out_item  = oq[oq_rd];
  assign raw_total = ({2'b00, pixels} << 1) + {2'b00, pixels};

  always_comb begin
    phase_next          = phase;
    acc_next            = acc;
    tlen_next           = tlen;
    line_start_next     = line_start;
    in_comment_next     = in_comment;
    digits_stopped_next = digits_stopped;
    token_overflow_next = token_overflow;
    error_latched_next  = error_latched;
    magic_p6_next       = magic_p6;
    frame_width_next    = frame_width;
    frame_height_next   = frame_height;
    raw_remaining_next  = raw_remaining;
    feed                = 1'b0;
    fin_req             = 1'b0;
    res_valid           = 1'b0;
    res.kind            = KIND_END;
    res.value           = '0;
    res.code            = ERR_NONE;
    res.last            = in_item.eof;
    acc_wide            = '0;

    if (!error_latched) begin
      unique case (phase)
        PH_EXPECT_P: begin
          if (in_item.is_p) begin
            phase_next          = PH_MAGIC;
            acc_next            = '0;
            tlen_next           = '0;
            digits_stopped_next = 1'b0;
            token_overflow_next = 1'b0;
          end else begin
            error_latched_next = 1'b1;
            res_valid          = 1'b1;
            res.kind           = KIND_ERROR;
            res.code           = ERR_NO_P;
          end
        end
        PH_MAGIC, PH_TOK_W, PH_TOK_H, PH_TOK_M, PH_TOK_S: begin
          if (in_item.is_ws) begin
            fin_req = 1'b1;
          end else begin
            feed = 1'b1;
          end
        end
        PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
          if (in_comment) begin
            if (in_item.is_lf) begin
              in_comment_next = 1'b0;
              line_start_next = 1'b1;
            end
          end else if (in_item.is_hash && line_start) begin
            in_comment_next = 1'b1;
          end else if (in_item.is_ws) begin
            line_start_next = in_item.is_lf;
          end else begin
            // first character of the next header token
            phase_next          = (phase == PH_SKIP_W) ? PH_TOK_W :
                                  (phase == PH_SKIP_H) ? PH_TOK_H : PH_TOK_M;
            acc_next            = '0;
            tlen_next           = '0;
            digits_stopped_next = 1'b0;
            token_overflow_next = 1'b0;
            feed                = 1'b1;
          end
        end
        PH_RAW: begin
          res_valid          = 1'b1;
          res.kind           = KIND_SAMPLE;
          res.value          = DIM_BITS'(in_item.data);
          raw_remaining_next = raw_remaining - 1'b1;
          if (raw_remaining == RAW_BITS'(1)) begin
            phase_next = PH_DONE;
          end
        end
        PH_SKIP_S: begin
          if (!in_item.is_ws) begin
            phase_next          = PH_TOK_S;
            acc_next            = '0;
            tlen_next           = '0;
            digits_stopped_next = 1'b0;
            token_overflow_next = 1'b0;
            feed                = 1'b1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    if (feed) begin
      tlen_next       = tlen_next + 1'b1;
      line_start_next = 1'b0;
      if (tlen_next > TLEN_BITS'(MAX_TOKEN_CHARS)) begin
        error_latched_next = 1'b1;
        res_valid          = 1'b1;
        res.kind           = KIND_ERROR;
        res.code           = ERR_TOO_LONG;
      end else if (!digits_stopped_next && in_item.is_digit) begin
        acc_wide = ({4'b0000, acc_next} << 3) + ({4'b0000, acc_next} << 1) +
                   ACC_WIDE_BITS'(in_item.digit);
        if (acc_wide > ACC_WIDE_BITS'(DIM_LIMIT)) begin
          acc_next            = DIM_LIMIT;
          token_overflow_next = 1'b1;
        end else begin
          acc_next = acc_wide[DIM_BITS-1:0];
        end
      end else begin
        digits_stopped_next = 1'b1;
      end
    end

    // the final byte closes a token that is still open
    do_fin = fin_req || (in_item.eof && !res_valid && !error_latched_next &&
                         is_token_phase(phase_next));
    fin_lf = fin_req ? in_item.is_lf : 1'b1;
    fin    = finish_token(phase_next, acc_next, token_overflow_next, magic_p6,
                          pixels != '0, max_dimension, max_maxval, max_sample);

    if (do_fin) begin
      line_start_next = fin_lf;
      in_comment_next = 1'b0;
      phase_next      = fin.phase;
      res_valid       = 1'b1;
      res.kind        = fin.kind;
      res.value       = fin.value;
      res.code        = fin.code;
      if (fin.fail) begin
        error_latched_next = 1'b1;
      end
      if (fin.set_magic) begin
        magic_p6_next = (fin.value == MAGIC_P6);
      end
      if (fin.set_width) begin
        frame_width_next = fin.value;
      end
      if (fin.set_height) begin
        frame_height_next = fin.value;
      end
      if (fin.load_raw) begin
        raw_remaining_next = raw_total;
      end
    end

    if (in_item.eof && !res_valid) begin
      res_valid = 1'b1;
      res.kind  = KIND_END;
    end

    // end of file: back to the start for the next file
    if (in_item.eof) begin
      phase_next          = PH_EXPECT_P;
      acc_next            = '0;
      tlen_next           = '0;
      line_start_next     = 1'b1;
      in_comment_next     = 1'b0;
      digits_stopped_next = 1'b0;
      token_overflow_next = 1'b0;
      error_latched_next  = 1'b0;
      magic_p6_next       = 1'b0;
      frame_width_next    = '0;
      frame_height_next   = '0;
      raw_remaining_next  = '0;
    end
  end

  // pixel count is registered from width and height
  always_ff @(posedge clk) begin
    pixels <= PIX_BITS'(frame_width) * PIX_BITS'(frame_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dimension <= MAX_DIM_RESET;
      max_maxval    <= MAX_MAXVAL_RESET;
      max_sample    <= MAX_SAMPLE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_DIMENSION: max_dimension <= cfg_data;
        CFG_MAX_MAXVAL:    max_maxval    <= cfg_data;
        CFG_MAX_SAMPLE:    max_sample    <= cfg_data[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_EXPECT_P;
      acc            <= '0;
      tlen           <= '0;
      line_start     <= 1'b1;
      in_comment     <= 1'b0;
      digits_stopped <= 1'b0;
      token_overflow <= 1'b0;
      error_latched  <= 1'b0;
      magic_p6       <= 1'b0;
      frame_width    <= '0;
      frame_height   <= '0;
      raw_remaining  <= '0;
    end else if (in_take) begin
      phase          <= phase_next;
      acc            <= acc_next;
      tlen           <= tlen_next;
      line_start     <= line_start_next;
      in_comment     <= in_comment_next;
      digits_stopped <= digits_stopped_next;
      token_overflow <= token_overflow_next;
      error_latched  <= error_latched_next;
      magic_p6       <= magic_p6_next;
      frame_width    <= frame_width_next;
      frame_height   <= frame_height_next;
      raw_remaining  <= raw_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[oq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
    end else begin
      if (res_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (res_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (res_push && !res_pop) begin
        oq_cnt <= oq_cnt + 1'b1;
      end else if (res_pop && !res_push) begin
        oq_cnt <= oq_cnt - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_err_has_code: assert property (@(posedge clk) disable iff (rst)
    res_push && res.kind == KIND_ERROR |-> res.code != ERR_NONE)
    else $error("error transaction without error code");

  a_ok_no_code: assert property (@(posedge clk) disable iff (rst)
    res_push && res.kind != KIND_ERROR |-> res.code == ERR_NONE)
    else $error("error code on a non-error transaction");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    in_take && in_item.eof |=> phase == PH_EXPECT_P && !error_latched)
    else $error("parser did not restart after end of file");

  a_raw_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RAW |-> raw_remaining != '0)
    else $error("raw phase with no bytes left");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> oq_cnt < OUT_CNT_BITS'(OUT_DEPTH) || res_pop)
    else $error("result queue overrun");
`endif

endmodule
